// ===== sv/ddh_pkg.sv =====
// shared types and constants for the distinct delta histogram
package ddh_pkg;

  localparam int STAMP_W = 64;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 5;
  localparam int LIMIT_W = 16;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  // apb register map
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_SAMPLE_LIMIT = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture stamps and form delta
    logic compare;  // register match and free vectors
    logic commit;   // update table and load output register
  } ddh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_room; // output register free or being drained this cycle
  } ddh_stat_t;

endpackage

// ===== sv/ddh_ctrl.sv =====
// sequencing state machine for the distinct delta histogram
module ddh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ddh_pkg::ddh_stat_t stat,
  output ddh_pkg::ddh_cmd_t  cmd
);
  import ddh_pkg::*;

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    MATCH  = 3'b010,
    UPDATE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = MATCH;
        end
      end
      MATCH: begin
        cmd.compare = 1'b1;
        state_next  = UPDATE;
      end
      UPDATE: begin
        // hold here until the previous result has been taken
        if (stat.out_room) begin
          cmd.commit = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ddh_datapath.sv =====
// delta, value table, counts and result register
module ddh_datapath #(
  parameter int ENTRIES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ddh_pkg::ddh_cmd_t              cmd,
  output ddh_pkg::ddh_stat_t             stat,
  input  logic [ddh_pkg::STAMP_W-1:0]    start_stamp,
  input  logic [ddh_pkg::STAMP_W-1:0]    end_stamp,
  input  logic [ddh_pkg::LIMIT_W-1:0]    sample_limit,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ddh_pkg::STAMP_W-1:0]    delta,
  output logic [ddh_pkg::SLOT_W-1:0]     slot,
  output logic [ddh_pkg::COUNT_W-1:0]    hit_count,
  output logic                           is_new,
  output logic                           rejected,
  output logic [ddh_pkg::LIMIT_W-1:0]    samples_taken
);
  import ddh_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [STAMP_W-1:0] delta_q;
  logic [STAMP_W-1:0] value_store [ENTRIES];
  logic [COUNT_W-1:0] count_store [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [LIMIT_W-1:0] accepted;
  logic               stopped;

  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   free_idx;
  logic               any_match;
  logic               any_free;
  logic               open_ok;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] inc_count;
  logic [IDX_W-1:0]   pick_idx;
  logic [IDX_W+SLOT_W-1:0] pick_ext;

  assign stat.out_room = !m_tvalid || m_tready;

  // lowest set bit of each vector
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign any_match = |match_vec;
  assign any_free  = |free_vec;
  assign open_ok   = !stopped && (accepted < sample_limit);
  assign cur_count = count_store[match_idx];
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
  assign pick_idx  = any_match ? match_idx : free_idx;
  // low slot bits of the entry number, zero extended for small tables
  assign pick_ext  = {{SLOT_W{1'b0}}, pick_idx};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delta_q <= end_stamp - start_stamp;
    end
    if (cmd.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        free_vec[i]  <= (count_store[i] == '0);
        match_vec[i] <= (count_store[i] != '0) && (value_store[i] == delta_q);
      end
    end
    if (cmd.commit && open_ok && !any_match && any_free) begin
      value_store[free_idx] <= delta_q;
    end
  end

  // counts reset to zero: a zero count marks a free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        count_store[i] <= '0;
      end
      accepted <= '0;
      stopped  <= 1'b0;
    end else if (cmd.commit && open_ok) begin
      if (any_match) begin
        count_store[match_idx] <= inc_count;
        accepted               <= accepted + LIMIT_W'(1);
      end else if (any_free) begin
        count_store[free_idx] <= COUNT_W'(1);
        accepted              <= accepted + LIMIT_W'(1);
      end else begin
        stopped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      delta <= delta_q;
      if (open_ok && (any_match || any_free)) begin
        slot          <= pick_ext[SLOT_W-1:0];
        hit_count     <= any_match ? inc_count : COUNT_W'(1);
        is_new        <= !any_match;
        rejected      <= 1'b0;
        samples_taken <= accepted + LIMIT_W'(1);
      end else begin
        slot          <= '0;
        hit_count     <= '0;
        is_new        <= 1'b0;
        rejected      <= 1'b1;
        samples_taken <= accepted;
      end
    end
  end

endmodule

// ===== sv/distinct_delta_histogram_top.sv =====
// top level: stream ports, apb register and the controller/datapath pair
// an input transfer passes the compare and update states before the result is valid
// items are handled one at a time, through the compare over all table entries
// followed by the update; a new item is taken while the last result still waits
// an unread result stalls the update stage until the output register drains
// reset (synchronous, active high): counts, samples and stopped flag cleared,
// sample_limit back to 500; no clearing pass, the table is usable at once
module distinct_delta_histogram_top #(
  parameter int ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ddh_pkg::IN_DATA_W-1:0]     s_tdata,   // start_stamp, end_stamp
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ddh_pkg::OUT_DATA_W-1:0]    m_tdata,   // delta, slot, hit_count,
                                                       // samples_taken, zero pad
  output logic [ddh_pkg::OUT_USER_W-1:0]    m_tuser,   // is_new, rejected
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ddh_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import ddh_pkg::*;

  ddh_cmd_t           cmd;
  ddh_stat_t          stat;
  logic [LIMIT_W-1:0] sample_limit;
  logic [STAMP_W-1:0] delta;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] hit_count;
  logic               is_new;
  logic               rejected;
  logic [LIMIT_W-1:0] samples_taken;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_SAMPLE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      sample_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - LIMIT_W){1'b0}}, sample_limit} : 32'd0;

  ddh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddh_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .start_stamp   (s_tdata[STAMP_W-1:0]),
    .end_stamp     (s_tdata[2*STAMP_W-1:STAMP_W]),
    .sample_limit  (sample_limit),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .delta         (delta),
    .slot          (slot),
    .hit_count     (hit_count),
    .is_new        (is_new),
    .rejected      (rejected),
    .samples_taken (samples_taken)
  );

  assign m_tdata = {3'b000, samples_taken, hit_count, slot, delta};
  assign m_tuser = {rejected, is_new};

  // one item at a time: a transfer in is never followed by another at once
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken in back-to-back cycles");

  // a counted item always reports a nonzero count
  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !rejected) |-> (hit_count != '0))
    else $error("accepted result with zero count");

  // a claimed entry starts at one
  a_new_is_one: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && is_new) |-> (!rejected && hit_count == COUNT_W'(1)))
    else $error("new entry with wrong count");

  // a rejected item carries no slot, count or claim
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && rejected) |-> (slot == '0 && hit_count == '0 && !is_new))
    else $error("rejected result carries table data");

endmodule
